FILE: design/rsi_pkg.sv
// Shared types and fixed widths for the ray against sphere pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;
  localparam int COORD_W = 32;              // coordinate width, 16 fraction bits
  localparam int DIR_W   = 16;              // direction component width
  localparam int RADIN_W = 31;              // base radius and scale width
  localparam int RAD_FRAC = 16;
  localparam int R_W     = 46;              // scaled radius width
  localparam int HALF_W  = 23;              // half of R_W for split squares
  localparam int SQ_W    = 2 * R_W;         // width of a square
  localparam int D2_W    = SQ_W + 2;        // sum of three squares
  localparam int VC_W    = COORD_W + 1;     // centre minus start
  localparam int PR_W    = VC_W + DIR_W;    // one dot product term
  localparam int ACC_W   = PR_W + 2;        // dot product sum

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] centre_z;
    logic [RADIN_W-1:0]        base_radius;
    logic [RADIN_W-1:0]        scale_factor;
    logic                      owned_by_camera;
  } in_req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
  } out_res_t;
endpackage
`default_nettype wire

FILE: design/ray_sphere_intersect.sv
// Top level of the pipelined ray against sphere intersection unit.
`timescale 1ns / 1ps
`default_nettype none
// Fully pipelined: one request is taken every clock cycle (busy is never
// raised) and its result appears on out_data with out_valid high for one
// cycle, once it has passed the projection and distance arithmetic, the
// square root (one root bit per stage) and the saturated near point logic.
// Results come back in request order; the receiver cannot stall them, so
// out_valid must be captured when it is seen. A miss (camera sphere, sphere
// behind the ray start, or ray passing outside the radius) gives hit = 0 and
// all coordinates zero.
module ray_sphere_intersect #(
  parameter int DIR_FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rsi_pkg::in_req_t  in_data,
  output logic                   out_valid,
  output rsi_pkg::out_res_t      out_data
);
  import rsi_pkg::*;

  localparam int TW     = ACC_W - DIR_FRAC_BITS;  // width of t
  localparam int SIDE_W = 1 + TW + 3*COORD_W + 3*DIR_W;

  logic                      d_valid, d_live, s_valid;
  logic [TW-1:0]             d_t;
  logic [SQ_W-1:0]           d_rad;
  logic signed [COORD_W-1:0] d_st [3];
  logic signed [DIR_W-1:0]   d_dv [3];
  logic [SIDE_W-1:0]         side_in, side_out;
  logic [R_W-1:0]            s_root;
  logic signed [COORD_W-1:0] p_st [3];
  logic signed [DIR_W-1:0]   p_dv [3];

  // no back-pressure anywhere in the pipe
  assign busy = 1'b0;

  rsi_dist #(.DIR_FRAC_BITS(DIR_FRAC_BITS), .TW(TW)) u_dist (
    .clk(clk), .rst_n(rst_n),
    .i_valid(start & ~busy), .i_data(in_data),
    .o_valid(d_valid), .o_live(d_live), .o_t(d_t), .o_rad(d_rad),
    .o_st(d_st), .o_dv(d_dv)
  );

  // data waiting for the root travels alongside the sqrt stages
  assign side_in = {d_live, d_t, d_st[0], d_st[1], d_st[2], d_dv[0], d_dv[1], d_dv[2]};

  rsi_sqrt #(.QW(R_W), .SIDE_W(SIDE_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n),
    .i_valid(d_valid), .i_rad(d_rad), .i_side(side_in),
    .o_valid(s_valid), .o_root(s_root), .o_side(side_out)
  );

  assign p_st[0] = side_out[3*DIR_W + 2*COORD_W +: COORD_W];
  assign p_st[1] = side_out[3*DIR_W + COORD_W +: COORD_W];
  assign p_st[2] = side_out[3*DIR_W +: COORD_W];
  assign p_dv[0] = side_out[2*DIR_W +: DIR_W];
  assign p_dv[1] = side_out[DIR_W +: DIR_W];
  assign p_dv[2] = side_out[0 +: DIR_W];

  rsi_point #(.DIR_FRAC_BITS(DIR_FRAC_BITS), .TW(TW), .QW(R_W)) u_point (
    .clk(clk), .rst_n(rst_n),
    .i_valid(s_valid), .i_live(side_out[SIDE_W-1]),
    .i_t(side_out[3*DIR_W + 3*COORD_W +: TW]), .i_h(s_root),
    .i_st(p_st), .i_dv(p_dv),
    .o_valid(out_valid), .o_data(out_data)
  );
endmodule
`default_nettype wire

FILE: design/rsi_dist.sv
// Front pipeline: projection t, squared distance, squared radius, sqrt operand.
`timescale 1ns / 1ps
`default_nettype none
module rsi_dist #(
  parameter int DIR_FRAC_BITS = 14,
  parameter int TW = rsi_pkg::ACC_W - 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                i_valid,
  input  wire rsi_pkg::in_req_t                    i_data,
  output logic                                     o_valid,
  output logic                                     o_live,
  output logic [TW-1:0]                            o_t,
  output logic [rsi_pkg::SQ_W-1:0]                 o_rad,
  output logic signed [rsi_pkg::COORD_W-1:0]       o_st [3],
  output logic signed [rsi_pkg::DIR_W-1:0]         o_dv [3]
);
  import rsi_pkg::*;

  localparam int PTW = DIR_W + TW + 1;
  localparam int SHW = PTW - DIR_FRAC_BITS;
  localparam int M1  = (SHW > VC_W) ? SHW : VC_W;
  localparam int EXW = ((M1 > R_W + 1) ? M1 : R_W + 1) + 1;

  logic [7:0] v_r, l_r;

  logic signed [COORD_W-1:0] st_r [8][3];
  logic signed [DIR_W-1:0]   dv_r [8][3];
  logic signed [VC_W-1:0]    vc_r [4][3];
  logic [2*RADIN_W-1:0]      rr1_r;
  logic [R_W-1:0]            r2s_r;
  logic signed [PR_W-1:0]    pr2_r [3];
  logic [TW-1:0]             t_r [6];
  logic [SQ_W-1:0]           rhh_r, rhl_r, rll_r;
  logic [SQ_W-1:0]           r2_r [4];
  logic signed [PTW-1:0]     pt4_r [3];
  logic [R_W-1:0]            m5_r [3];
  logic [SQ_W-1:0]           mhh_r [3], mhl_r [3], mll_r [3];
  logic [SQ_W-1:0]           sq7_r [3];
  logic [SQ_W-1:0]           rad8_r;

  logic signed [ACC_W-1:0]   acc;
  logic signed [PTW-1:0]     sh [3];
  logic signed [EXW-1:0]     e [3];
  logic [EXW-1:0]            eabs [3];
  logic [2:0]                far;
  logic [D2_W-1:0]           d2;
  logic [HALF_W-1:0]         rh, rl;

  always_comb begin
    acc = ACC_W'(pr2_r[0]) + ACC_W'(pr2_r[1]) + ACC_W'(pr2_r[2]);
    rh  = r2s_r[R_W-1:HALF_W];
    rl  = r2s_r[HALF_W-1:0];
    for (int i = 0; i < 3; i++) begin
      sh[i]   = pt4_r[i] >>> DIR_FRAC_BITS;
      e[i]    = EXW'(sh[i]) - EXW'(vc_r[3][i]);
      eabs[i] = e[i][EXW-1] ? EXW'(-e[i]) : EXW'(e[i]);
      far[i]  = |eabs[i][EXW-1:R_W];
    end
    d2 = D2_W'(sq7_r[0]) + D2_W'(sq7_r[1]) + D2_W'(sq7_r[2]);
  end

  // valid and live bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      l_r <= '0;
    end else begin
      v_r <= {v_r[6:0], i_valid};
      l_r[0] <= !i_data.owned_by_camera;
      l_r[1] <= l_r[0];
      l_r[2] <= l_r[1] & !acc[ACC_W-1];
      l_r[3] <= l_r[2];
      l_r[4] <= l_r[3] & !(|far);
      l_r[5] <= l_r[4];
      l_r[6] <= l_r[5];
      l_r[7] <= l_r[6] & (d2 <= D2_W'(r2_r[3]));
    end
  end

  always_ff @(posedge clk) begin
    st_r[0][0] <= i_data.start_x;
    st_r[0][1] <= i_data.start_y;
    st_r[0][2] <= i_data.start_z;
    dv_r[0][0] <= i_data.dir_x;
    dv_r[0][1] <= i_data.dir_y;
    dv_r[0][2] <= i_data.dir_z;
    vc_r[0][0] <= VC_W'(i_data.centre_x) - VC_W'(i_data.start_x);
    vc_r[0][1] <= VC_W'(i_data.centre_y) - VC_W'(i_data.start_y);
    vc_r[0][2] <= VC_W'(i_data.centre_z) - VC_W'(i_data.start_z);
    rr1_r <= (2*RADIN_W)'(i_data.base_radius) * (2*RADIN_W)'(i_data.scale_factor);
    for (int k = 1; k < 8; k++) begin
      st_r[k] <= st_r[k-1];
      dv_r[k] <= dv_r[k-1];
    end
    for (int k = 1; k < 4; k++) vc_r[k] <= vc_r[k-1];
    // stage 2
    r2s_r <= rr1_r[RAD_FRAC +: R_W];
    for (int i = 0; i < 3; i++) pr2_r[i] <= vc_r[0][i] * dv_r[0][i];
    // stage 3
    t_r[0] <= acc[ACC_W-1:DIR_FRAC_BITS];
    rhh_r <= SQ_W'(rh) * SQ_W'(rh);
    rhl_r <= SQ_W'(rh) * SQ_W'(rl);
    rll_r <= SQ_W'(rl) * SQ_W'(rl);
    for (int k = 1; k < 6; k++) t_r[k] <= t_r[k-1];
    // stage 4
    r2_r[0] <= (rhh_r << (2*HALF_W)) + (rhl_r << (HALF_W + 1)) + rll_r;
    for (int k = 1; k < 4; k++) r2_r[k] <= r2_r[k-1];
    for (int i = 0; i < 3; i++) begin
      pt4_r[i] <= dv_r[2][i] * $signed({1'b0, t_r[0]});
      // stage 5
      m5_r[i] <= eabs[i][R_W-1:0];
      // stage 6
      mhh_r[i] <= SQ_W'(m5_r[i][R_W-1:HALF_W]) * SQ_W'(m5_r[i][R_W-1:HALF_W]);
      mhl_r[i] <= SQ_W'(m5_r[i][R_W-1:HALF_W]) * SQ_W'(m5_r[i][HALF_W-1:0]);
      mll_r[i] <= SQ_W'(m5_r[i][HALF_W-1:0]) * SQ_W'(m5_r[i][HALF_W-1:0]);
      // stage 7
      sq7_r[i] <= (mhh_r[i] << (2*HALF_W)) + (mhl_r[i] << (HALF_W + 1)) + mll_r[i];
    end
    // stage 8
    rad8_r <= r2_r[3] - d2[SQ_W-1:0];
  end

  assign o_valid = v_r[7];
  assign o_live  = l_r[7];
  assign o_t     = t_r[5];
  assign o_rad   = rad8_r;
  assign o_st    = st_r[7];
  assign o_dv    = dv_r[7];
endmodule
`default_nettype wire

FILE: design/rsi_sqrt.sv
// Pipelined floor square root, one result bit per stage, side data carried along.
`timescale 1ns / 1ps
`default_nettype none
module rsi_sqrt #(
  parameter int QW = 46,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              i_valid,
  input  wire logic [2*QW-1:0]   i_rad,
  input  wire logic [SIDE_W-1:0] i_side,
  output logic                   o_valid,
  output logic [QW-1:0]          o_root,
  output logic [SIDE_W-1:0]      o_side
);
  localparam int RW  = 2 * QW;
  localparam int RMW = QW + 2;

  logic              v_r    [QW];
  logic [RMW-1:0]    rem_r  [QW];
  logic [QW-1:0]     root_r [QW];
  logic [RW-1:0]     rad_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              v_in;
    logic [RMW-1:0]    rem_in;
    logic [QW-1:0]     root_in;
    logic [RW-1:0]     rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [RMW+1:0]    cur, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = i_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = i_rad;
      assign side_in = i_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      cur   = {rem_in, rad_in[RW-1-2*k -: 2]};
      trial = {2'b00, root_in, 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else        v_r[k] <= v_in;
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? RMW'(cur - trial) : RMW'(cur);
      root_r[k] <= {root_in[QW-2:0], ge};
      rad_r[k]  <= rad_in;
      side_r[k] <= side_in;
    end
  end

  assign o_valid = v_r[QW-1];
  assign o_root  = root_r[QW-1];
  assign o_side  = side_r[QW-1];
endmodule
`default_nettype wire

FILE: design/rsi_point.sv
// Back pipeline: near point start + dir*(t - h), saturated, zero on a miss.
`timescale 1ns / 1ps
`default_nettype none
module rsi_point #(
  parameter int DIR_FRAC_BITS = 14,
  parameter int TW = 37,
  parameter int QW = 46
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          i_valid,
  input  wire logic                          i_live,
  input  wire logic [TW-1:0]                 i_t,
  input  wire logic [QW-1:0]                 i_h,
  input  wire logic signed [rsi_pkg::COORD_W-1:0] i_st [3],
  input  wire logic signed [rsi_pkg::DIR_W-1:0]   i_dv [3],
  output logic                               o_valid,
  output rsi_pkg::out_res_t                  o_data
);
  import rsi_pkg::*;

  localparam int SW  = ((TW > QW) ? TW : QW) + 2;
  localparam int PW  = DIR_W + SW;
  localparam int M1  = PW - DIR_FRAC_BITS;
  localparam int QXW = ((M1 > COORD_W) ? M1 : COORD_W) + 1;
  localparam logic signed [QXW-1:0] QMAX = {{(QXW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [QXW-1:0] QMIN = {{(QXW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  logic                      v_r, l_r, vo_r;
  logic signed [PW-1:0]      pr_r [3];
  logic signed [COORD_W-1:0] st_r [3];
  out_res_t                  res_r;

  logic signed [SW-1:0]      sn;
  logic signed [PW-1:0]      sh [3];
  logic signed [QXW-1:0]     q  [3];
  logic signed [COORD_W-1:0] qs [3];

  always_comb begin
    sn = $signed(SW'(i_t)) - $signed(SW'(i_h));
    for (int i = 0; i < 3; i++) begin
      sh[i] = pr_r[i] >>> DIR_FRAC_BITS;
      q[i]  = QXW'(st_r[i]) + QXW'(sh[i]);
      if (q[i] > QMAX)      qs[i] = QMAX[COORD_W-1:0];
      else if (q[i] < QMIN) qs[i] = QMIN[COORD_W-1:0];
      else                  qs[i] = q[i][COORD_W-1:0];
      if (!l_r) qs[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= i_valid;
      vo_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    l_r <= i_live;
    for (int i = 0; i < 3; i++) begin
      pr_r[i] <= i_dv[i] * sn;
      st_r[i] <= i_st[i];
    end
    res_r.hit   <= l_r;
    res_r.hit_x <= qs[0];
    res_r.hit_y <= qs[1];
    res_r.hit_z <= qs[2];
  end

  assign o_valid = vo_r;
  assign o_data  = res_r;
endmodule
`default_nettype wire

FILE: bench/ray_sphere_intersect_tb.sv
// Self-checking testbench for the ray against sphere intersection unit.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_intersect_tb;
  import rsi_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int    N_RANDOM = 800;
  localparam int    DRAIN    = 80;          // a little over the pipe depth
  localparam wide_t FAR      = wide_t'(1) <<< 46;
  localparam wide_t CMAX     = (wide_t'(1) <<< (COORD_W - 1)) - 1;
  localparam wide_t CMIN     = -(wide_t'(1) <<< (COORD_W - 1));
  localparam logic signed [COORD_W-1:0] ONE = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam logic signed [DIR_W-1:0]   DU  = 16'sd16384;      // 1.0 in Q2.14

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_data = '0;
  logic     out_valid;
  out_res_t out_data;

  out_res_t hits_due[$];     // expected results, oldest first
  int       n_err = 0;

  // per-request expectation handed from the driver to the accept monitor
  logic     fixed_pending = 1'b0;
  out_res_t fixed_res;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ray_sphere_intersect i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Bit-exact intersection predictor: wide signed maths throughout, so no
  // intermediate ever wraps.
  function automatic out_res_t predict_hit(in_req_t q);
    wide_t      st[3], dv[3], vc[3], e;
    wide_t      acc, t, r, r2, d2, rem, h, cand, sn, p;
    logic [61:0] rprod;
    out_res_t   res;
    res = '0;
    if (q.owned_by_camera) return res;
    st[0] = q.start_x;  st[1] = q.start_y;  st[2] = q.start_z;
    dv[0] = q.dir_x;    dv[1] = q.dir_y;    dv[2] = q.dir_z;
    vc[0] = wide_t'(q.centre_x) - st[0];
    vc[1] = wide_t'(q.centre_y) - st[1];
    vc[2] = wide_t'(q.centre_z) - st[2];
    acc = 0;
    for (int i = 0; i < 3; i++) acc += vc[i] * dv[i];
    if (acc < 0) return res;                       // sphere behind the start
    t = acc >>> 14;
    rprod = q.base_radius * q.scale_factor;
    r = rprod >> RAD_FRAC;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      e = ((dv[i] * t) >>> 14) - vc[i];
      if (e >= FAR || e <= -FAR) return res;       // far miss
      d2 += e * e;
    end
    r2 = r * r;
    if (d2 > r2) return res;                       // passes outside
    rem = r2 - d2;
    h = 0;
    for (int b = 46; b >= 0; b--) begin
      cand = h | (wide_t'(1) <<< b);
      if (cand * cand <= rem) h = cand;
    end
    sn = t - h;
    for (int i = 0; i < 3; i++) begin
      p = st[i] + ((dv[i] * sn) >>> 14);
      if (p > CMAX) p = CMAX;
      else if (p < CMIN) p = CMIN;
      case (i)
        0: res.hit_x = p[COORD_W-1:0];
        1: res.hit_y = p[COORD_W-1:0];
        default: res.hit_z = p[COORD_W-1:0];
      endcase
    end
    res.hit = 1'b1;
    return res;
  endfunction

  function automatic in_req_t mk_req(
    logic signed [31:0] sx, sy, sz,
    logic signed [15:0] dx, dy, dz,
    logic signed [31:0] cx, cy, cz,
    logic [30:0] br, sf, logic cam);
    in_req_t q;
    q = '{sx, sy, sz, dx, dy, dz, cx, cy, cz, br, sf, cam};
    return q;
  endfunction

  // Random request: mostly a ray aimed near a sphere with random content,
  // the rest with start, centre and radius noise across their whole ranges.
  function automatic in_req_t random_req();
    in_req_t q;
    logic signed [31:0] off;
    q.dir_x = $signed(16'($urandom_range(32768))) - 16'sd16384;
    q.dir_y = $signed(16'($urandom_range(32768))) - 16'sd16384;
    q.dir_z = $signed(16'($urandom_range(32768))) - 16'sd16384;
    q.owned_by_camera = ($urandom_range(99) < 8);
    if ($urandom_range(99) < 15) begin
      q.start_x = $urandom;  q.start_y = $urandom;  q.start_z = $urandom;
      q.centre_x = $urandom; q.centre_y = $urandom; q.centre_z = $urandom;
      q.base_radius = 31'($urandom); q.scale_factor = 31'($urandom);
    end else begin
      q.start_x = $signed(32'($urandom_range(32'h0200_0000))) - 32'sh0100_0000;
      q.start_y = $signed(32'($urandom_range(32'h0200_0000))) - 32'sh0100_0000;
      q.start_z = $signed(32'($urandom_range(32'h0200_0000))) - 32'sh0100_0000;
      // centre placed roughly along the ray, with a random miss offset
      off = $signed(32'($urandom_range(2000)));
      q.centre_x = q.start_x + ((q.dir_x * off) <<< 2) + $signed(32'($urandom_range(8191))) - 4096;
      q.centre_y = q.start_y + ((q.dir_y * off) <<< 2) + $signed(32'($urandom_range(8191))) - 4096;
      q.centre_z = q.start_z + ((q.dir_z * off) <<< 2) + $signed(32'($urandom_range(8191))) - 4096;
      q.base_radius  = 31'($urandom_range(32'h0040_0000));
      q.scale_factor = 31'($urandom_range(32'h0002_0000, 32'h0000_4000));
    end
    return q;
  endfunction

  // Accept monitor and result checker; all ports change by NBA at the edge,
  // so the values read here are the ones from before it.
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && start && !busy) begin
      if (fixed_pending) hits_due.push_back(fixed_res);
      else hits_due.push_back(predict_hit(in_data));
    end
    if (rst_n && out_valid) begin
      if (hits_due.size() == 0) begin
        $error("result with no request outstanding");
        n_err++;
      end else begin
        want = hits_due.pop_front();
        if (out_data.hit !== want.hit) begin
          $error("hit exp %0d got %0d", want.hit, out_data.hit); n_err++;
        end
        if (out_data.hit_x !== want.hit_x) begin
          $error("hit_x exp %0d got %0d", want.hit_x, out_data.hit_x); n_err++;
        end
        if (out_data.hit_y !== want.hit_y) begin
          $error("hit_y exp %0d got %0d", want.hit_y, out_data.hit_y); n_err++;
        end
        if (out_data.hit_z !== want.hit_z) begin
          $error("hit_z exp %0d got %0d", want.hit_z, out_data.hit_z); n_err++;
        end
      end
    end
  end

  // Offer one request and hold it until taken; start stays high when the
  // next request follows straight on.
  task automatic send_req(in_req_t q, bit has_fixed, out_res_t fx, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 17) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start         <= 1'b1;
    in_data       <= q;
    fixed_pending <= has_fixed;
    fixed_res     <= fx;
    do @(posedge clk); while (busy);
  endtask

  typedef struct {
    in_req_t  req;
    bit       has_fixed;
    out_res_t res;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    out_res_t miss;
    miss = '0;
    // camera sphere: never hit, even dead ahead
    directed.push_back('{mk_req(0, 0, 0, DU, 0, 0, 10 * ONE, 0, 0, ONE, ONE, 1'b1), 1, miss});
    // sphere behind the start
    directed.push_back('{mk_req(0, 0, 0, DU, 0, 0, -10 * ONE, 0, 0, ONE, ONE, 1'b0), 1, miss});
    // passes well outside the radius
    directed.push_back('{mk_req(0, 0, 0, DU, 0, 0, 10 * ONE, 5 * ONE, 0, ONE, ONE, 1'b0),
                        1, miss});
    // extremes with camera flag set
    directed.push_back('{mk_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                 DU, DU, DU, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1), 1, miss});
    // plain hit, tangent, start at the sphere centre (t = 0)
    directed.push_back('{mk_req(0, 0, 0, DU, 0, 0, 10 * ONE, 0, 0, ONE, ONE, 1'b0), 0, miss});
    directed.push_back('{mk_req(0, 0, 0, DU, 0, 0, 10 * ONE, ONE, 0, ONE, ONE, 1'b0), 0, miss});
    directed.push_back('{mk_req(0, 0, 0, 0, DU, 0, 0, 0, 0, 2 * ONE, ONE, 1'b0), 0, miss});
    // zero radius on the ray and just off it
    directed.push_back('{mk_req(0, 0, 0, 0, 0, DU, 0, 0, 7 * ONE, 0, ONE, 1'b0), 0, miss});
    directed.push_back('{mk_req(0, 0, 0, 0, 0, DU, 1, 0, 7 * ONE, 0, 0, 1'b0), 0, miss});
    // start inside the sphere, negative directions
    directed.push_back('{mk_req(ONE, ONE, ONE, -DU, 0, 0, 0, ONE, ONE, 5 * ONE, ONE, 1'b0),
                        0, miss});
    // direction not unit length
    directed.push_back('{mk_req(0, 0, 0, DU, DU, DU, 4 * ONE, 4 * ONE, 4 * ONE, ONE, 2 * ONE,
                                 1'b0), 0, miss});
    directed.push_back('{mk_req(0, 0, 0, -DU, -DU, -DU, -3 * ONE, -3 * ONE, -3 * ONE,
                                 ONE, ONE, 1'b0), 0, miss});
    // huge offset and huge radius, still a hit
    directed.push_back('{mk_req(32'sh8000_0000, 32'sh8000_0000, 0, DU, 0, 0,
                                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
                                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0), 0, miss});
    // saturation at both ends of the coordinate range
    directed.push_back('{mk_req(32'sh8000_0000, 0, 0, DU, 0, 0, 32'sh8001_0000, 0, 0,
                                 1000 * ONE, ONE, 1'b0), 0, miss});
    directed.push_back('{mk_req(32'sh7FFF_FFFF, 0, 0, -DU, 0, 0, 32'sh7FFE_FFFF, 0, 0,
                                 1000 * ONE, ONE, 1'b0), 0, miss});
    // largest radius and scale, with a zero and with a diagonal direction
    directed.push_back('{mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                 1'b0), 0, miss});
    directed.push_back('{mk_req(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                 -DU, DU, -DU, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0), 0, miss});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_req(directed[k].req, directed[k].has_fixed, directed[k].res, 1);
    // requests 300 to 549 of the random run go back to back
    for (int k = 0; k < N_RANDOM; k++)
      send_req(random_req(), 0, miss, !(k >= 300 && k < 550));
    start <= 1'b0;

    while (hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_err == 0)
      $display("ray_sphere_intersect_tb OK");
    else
      $display("ray_sphere_intersect_tb NOT OK");
    $finish;
  end

  // watchdog: a correct run needs well under a tenth of this
  initial begin
    #2_000_000;
    $display("ray_sphere_intersect_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

FILE: ray_sphere_intersect.f
design/rsi_pkg.sv
design/rsi_dist.sv
design/rsi_sqrt.sv
design/rsi_point.sv
design/ray_sphere_intersect.sv
bench/ray_sphere_intersect_tb.sv
